// ----- src/smx_pkg.sv -----
// ----------------------------------------------------------------------------
// smx_pkg
// shared constants, opcodes and types of the stack machine executor
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int STACK_DEPTH   = 1024;
  localparam int DISPLAY_DEPTH = 8;
  localparam int PROGRAM_DEPTH = 4096;

  localparam int AW      = $clog2(STACK_DEPTH);
  localparam int SP_W    = AW + 1;
  localparam int DISP_AW = (DISPLAY_DEPTH > 1) ? $clog2(DISPLAY_DEPTH) : 1;
  localparam int FA_W    = SP_W + 2;

  localparam int KIND_W  = 5;
  localparam int LEVEL_W = 3;
  localparam int OFF_W   = 11;
  localparam int DATA_W  = 32;
  localparam int PC_W    = 12;
  localparam int ST_W    = 2;

  localparam logic [KIND_W-1:0] OP_CRCT = 5'd0;
  localparam logic [KIND_W-1:0] OP_SOMA = 5'd1;
  localparam logic [KIND_W-1:0] OP_SUBT = 5'd2;
  localparam logic [KIND_W-1:0] OP_MULT = 5'd3;
  localparam logic [KIND_W-1:0] OP_DIVI = 5'd4;
  localparam logic [KIND_W-1:0] OP_INVR = 5'd5;
  localparam logic [KIND_W-1:0] OP_CONJ = 5'd6;
  localparam logic [KIND_W-1:0] OP_DISJ = 5'd7;
  localparam logic [KIND_W-1:0] OP_NEGA = 5'd8;
  localparam logic [KIND_W-1:0] OP_CMME = 5'd9;
  localparam logic [KIND_W-1:0] OP_CMMA = 5'd10;
  localparam logic [KIND_W-1:0] OP_CMIG = 5'd11;
  localparam logic [KIND_W-1:0] OP_CMDG = 5'd12;
  localparam logic [KIND_W-1:0] OP_CMEG = 5'd13;
  localparam logic [KIND_W-1:0] OP_CMAG = 5'd14;
  localparam logic [KIND_W-1:0] OP_DSVS = 5'd15;
  localparam logic [KIND_W-1:0] OP_DSVF = 5'd16;
  localparam logic [KIND_W-1:0] OP_NADA = 5'd17;
  localparam logic [KIND_W-1:0] OP_LEIT = 5'd18;
  localparam logic [KIND_W-1:0] OP_IMPR = 5'd19;
  localparam logic [KIND_W-1:0] OP_INPP = 5'd20;
  localparam logic [KIND_W-1:0] OP_AMEM = 5'd21;
  localparam logic [KIND_W-1:0] OP_PARA = 5'd22;
  localparam logic [KIND_W-1:0] OP_CRVL = 5'd23;
  localparam logic [KIND_W-1:0] OP_ARMZ = 5'd24;
  localparam logic [KIND_W-1:0] OP_CHPR = 5'd25;
  localparam logic [KIND_W-1:0] OP_ENPR = 5'd26;
  localparam logic [KIND_W-1:0] OP_DMEM = 5'd27;
  localparam logic [KIND_W-1:0] OP_RTPR = 5'd28;
  localparam logic [KIND_W-1:0] OP_CRVI = 5'd29;
  localparam logic [KIND_W-1:0] OP_ARMI = 5'd30;
  localparam logic [KIND_W-1:0] OP_CREN = 5'd31;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_DIV0  = 2'd1;
  localparam logic [ST_W-1:0] ST_STACK = 2'd2;
  localparam logic [ST_W-1:0] ST_ADDR  = 2'd3;

  typedef struct packed {
    logic              start;
    logic [KIND_W-1:0] op;
  } smx_alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } smx_alu_rsp_t;

endpackage

// ----- src/smx_if.sv -----
// ----------------------------------------------------------------------------
// smx_if
// instruction and result channels of the stack machine executor
// ----------------------------------------------------------------------------
interface smx_in_if;
  logic                              valid;
  logic                              ready;
  logic [smx_pkg::KIND_W-1:0]        kind;
  logic [smx_pkg::LEVEL_W-1:0]       level;
  logic signed [smx_pkg::OFF_W-1:0]  offset;
  logic signed [smx_pkg::DATA_W-1:0] constant;
  logic [smx_pkg::PC_W-1:0]          target;
  logic signed [smx_pkg::DATA_W-1:0] read_value;

  modport source (output valid, kind, level, offset, constant, target, read_value,
                  input ready);
  modport sink (input valid, kind, level, offset, constant, target, read_value,
                output ready);
endinterface

interface smx_out_if;
  logic                              valid;
  logic                              ready;
  logic [smx_pkg::PC_W-1:0]          next_pc;
  logic                              print_valid;
  logic signed [smx_pkg::DATA_W-1:0] print_value;
  logic                              halted;
  logic [smx_pkg::ST_W-1:0]          status;

  modport source (output valid, next_pc, print_valid, print_value, halted, status,
                  input ready);
  modport sink (input valid, next_pc, print_valid, print_value, halted, status,
                output ready);
endinterface

// ----- src/smx_ram.sv -----
// ----------------------------------------------------------------------------
// smx_ram
// generic single write, single registered read memory
// ----------------------------------------------------------------------------
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/smx_alu.sv -----
// ----------------------------------------------------------------------------
// smx_alu
// shared arithmetic and compare unit with an iterative signed divider
// ----------------------------------------------------------------------------
module smx_alu (
  input  logic                         clk,
  input  logic                         rst_n,
  input  smx_pkg::smx_alu_req_t        req,
  input  logic [smx_pkg::DATA_W-1:0]   x,
  input  logic [smx_pkg::DATA_W-1:0]   y,
  output logic [smx_pkg::DATA_W-1:0]   result,
  output logic [smx_pkg::DATA_W-1:0]   quotient,
  output smx_pkg::smx_alu_rsp_t        rsp
);

  localparam int DW = smx_pkg::DATA_W;

  logic [DW-1:0]          rem_r, rem_nxt;
  logic [DW-1:0]          quo_r, quo_nxt;
  logic [DW-1:0]          dv_r, dv_nxt;
  logic                   neg_r, neg_nxt;
  logic [$clog2(DW)-1:0]  cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [DW:0]            shifted;
  logic [DW:0]            diff;
  logic [2*DW-1:0]        prod;
  logic signed [DW-1:0]   sx, sy;

  assign sx   = $signed(x);
  assign sy   = $signed(y);
  assign prod = x * y;

  always_comb begin
    result = '0;
    unique case (req.op)
      smx_pkg::OP_SOMA: result = x + y;
      smx_pkg::OP_SUBT: result = x - y;
      smx_pkg::OP_MULT: result = prod[DW-1:0];
      smx_pkg::OP_CONJ: result = DW'(x == DW'(1) && y == DW'(1));
      smx_pkg::OP_DISJ: result = DW'(x == DW'(1) || y == DW'(1));
      smx_pkg::OP_CMME: result = DW'(sx < sy);
      smx_pkg::OP_CMMA: result = DW'(sx > sy);
      smx_pkg::OP_CMIG: result = DW'(sx == sy);
      smx_pkg::OP_CMDG: result = DW'(sx != sy);
      smx_pkg::OP_CMEG: result = DW'(sx <= sy);
      smx_pkg::OP_CMAG: result = DW'(sx >= sy);
      default:          result = '0;
    endcase
  end

  assign shifted = {rem_r, quo_r[DW-1]};
  assign diff    = shifted - {1'b0, dv_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dv_nxt   = dv_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = x[DW-1] ? -x : x;
      dv_nxt   = y[DW-1] ? -y : y;
      neg_nxt  = x[DW-1] ^ y[DW-1];
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (!diff[DW]) begin
        rem_nxt = diff[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == $clog2(DW)'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dv_r  <= dv_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient = neg_r ? -quo_r : quo_r;
  assign rsp.busy = busy_r;
  assign rsp.done = done_r;

  div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start)
    else $error("divider restarted while busy");

endmodule

// ----- src/stack_machine_executor.sv -----
// ----------------------------------------------------------------------------
// stack_machine_executor
// executes one decoded instruction of a pascal-style stack machine per beat
// ----------------------------------------------------------------------------
// in_ch carries one decoded instruction per beat, out_ch one result beat
// (next pc, print value, halt flag, status) per instruction.
// after reset the data stack is cleared one entry a cycle; in_ch.ready
// stays low until it is done. an instruction then passes from accept to
// result beat through decode, up to two reads of the stack memory
// (indirect loads and stores, two-operand ops and return read twice), and
// the result register, and the machine returns to idle before the next
// accept. a divide also runs the shared unit's bit-serial divider.
// one instruction is in flight at a time; the next one is accepted as soon
// as its predecessor's result sits in the output register.
// a stalled receiver holds the result beat; the following instruction
// finishes its work and waits until that register frees up.
// once halt executes the machine state is frozen and each beat only
// reports the current pc with halted set.
// ----------------------------------------------------------------------------
module stack_machine_executor (
  input  logic       clk,
  input  logic       rst_n,
  smx_in_if.sink     in_ch,
  smx_out_if.source  out_ch
);

  localparam int AW   = smx_pkg::AW;
  localparam int SW   = smx_pkg::SP_W;
  localparam int FW   = smx_pkg::FA_W;
  localparam int DW   = smx_pkg::DATA_W;
  localparam int PW   = smx_pkg::PC_W;
  localparam int DAW  = smx_pkg::DISP_AW;
  localparam int OW   = smx_pkg::OFF_W;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_R1   = 3'd3;
  localparam logic [2:0] S_R2   = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]                  state_r, state_nxt;
  logic [AW-1:0]               clr_r, clr_nxt;
  logic [smx_pkg::KIND_W-1:0]  kind_r, kind_nxt;
  logic [smx_pkg::LEVEL_W-1:0] lvl_r, lvl_nxt;
  logic [OW-1:0]               off_r, off_nxt;
  logic [DW-1:0]               cst_r, cst_nxt;
  logic [PW-1:0]               tgt_r, tgt_nxt;
  logic [DW-1:0]               rdv_r, rdv_nxt;
  logic [SW-1:0]               sp_r, sp_nxt;
  logic [PW-1:0]               pc_r, pc_nxt;
  logic [PW-1:0]               npc_r, npc_nxt;
  logic                        halt_r, halt_nxt;
  logic [SW-1:0]               disp_r [smx_pkg::DISPLAY_DEPTH];
  logic [SW-1:0]               disp_nxt [smx_pkg::DISPLAY_DEPTH];
  logic [AW-1:0]               a_r, a_nxt;
  logic [DW-1:0]               y_r, y_nxt;
  logic [smx_pkg::ST_W-1:0]    st_r, st_nxt;
  logic                        pv_r, pv_nxt;
  logic [DW-1:0]               pval_r, pval_nxt;
  logic                        ov_r, ov_nxt;
  logic [PW-1:0]               o_pc_r, o_pc_nxt;
  logic                        o_pv_r, o_pv_nxt;
  logic [DW-1:0]               o_pval_r, o_pval_nxt;
  logic                        o_halt_r, o_halt_nxt;
  logic [smx_pkg::ST_W-1:0]    o_st_r, o_st_nxt;

  logic                        we;
  logic [AW-1:0]               waddr, raddr;
  logic [DW-1:0]               wdata, rdata;
  smx_pkg::smx_alu_req_t       alu_req;
  smx_pkg::smx_alu_rsp_t       alu_rsp;
  logic [DW-1:0]               alu_res, alu_quo;

  logic [AW-1:0]               top_idx, sec_idx, push_idx;
  logic [SW-1:0]               disp_sel;
  logic signed [FW-1:0]        off_x, fa, amem_t, dmem_t, rt_t;
  logic                        fa_ok, amem_ok, dmem_ok, rt_ok;
  logic                        lvl_bad, tgt_bad, can_push, has1, has2;
  logic [PW:0]                 pc_add;
  logic [PW-1:0]               pc_inc;
  logic                        rd_addr_ok, rd_ret_ok, base_ok;
  logic                        out_free;

  smx_ram #(.WIDTH(DW), .DEPTH(smx_pkg::STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  smx_alu u_alu (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (alu_req),
    .x        (rdata),
    .y        (y_r),
    .result   (alu_res),
    .quotient (alu_quo),
    .rsp      (alu_rsp)
  );

  assign top_idx  = AW'(sp_r - SW'(1));
  assign sec_idx  = AW'(sp_r - SW'(2));
  assign push_idx = AW'(sp_r);
  assign disp_sel = disp_r[lvl_r[DAW-1:0]];
  assign off_x    = FW'($signed(off_r));
  assign fa       = $signed({2'b00, disp_sel}) + off_x;
  assign amem_t   = $signed({2'b00, sp_r}) + off_x;
  assign dmem_t   = $signed({2'b00, sp_r}) - off_x;
  assign rt_t     = $signed({2'b00, sp_r}) - off_x - FW'(2);
  assign fa_ok    = !fa[FW-1] && (fa < FW'(smx_pkg::STACK_DEPTH));
  assign amem_ok  = !amem_t[FW-1] && (amem_t <= FW'(smx_pkg::STACK_DEPTH));
  assign dmem_ok  = !dmem_t[FW-1] && (dmem_t <= FW'(smx_pkg::STACK_DEPTH));
  assign rt_ok    = !rt_t[FW-1] && (rt_t <= FW'(smx_pkg::STACK_DEPTH));
  assign lvl_bad  = 32'(lvl_r) >= 32'(smx_pkg::DISPLAY_DEPTH);
  assign tgt_bad  = 32'(tgt_r) >= 32'(smx_pkg::PROGRAM_DEPTH);
  assign can_push = 32'(sp_r) < 32'(smx_pkg::STACK_DEPTH);
  assign has1     = sp_r >= SW'(1);
  assign has2     = sp_r >= SW'(2);
  assign pc_add   = {1'b0, pc_r} + (PW+1)'(1);
  assign pc_inc   = (32'(pc_add) >= 32'(smx_pkg::PROGRAM_DEPTH)) ? '0 : pc_add[PW-1:0];
  assign rd_addr_ok = !rdata[DW-1] && (rdata < DW'(smx_pkg::STACK_DEPTH));
  assign rd_ret_ok  = !rdata[DW-1] && (rdata < DW'(smx_pkg::PROGRAM_DEPTH));
  assign base_ok    = !y_r[DW-1] && (y_r <= DW'(smx_pkg::STACK_DEPTH));
  assign out_free   = !ov_r || out_ch.ready;

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    kind_nxt  = kind_r;
    lvl_nxt   = lvl_r;
    off_nxt   = off_r;
    cst_nxt   = cst_r;
    tgt_nxt   = tgt_r;
    rdv_nxt   = rdv_r;
    sp_nxt    = sp_r;
    pc_nxt    = pc_r;
    npc_nxt   = npc_r;
    halt_nxt  = halt_r;
    disp_nxt  = disp_r;
    a_nxt     = a_r;
    y_nxt     = y_r;
    st_nxt    = st_r;
    pv_nxt    = pv_r;
    pval_nxt  = pval_r;
    we        = 1'b0;
    waddr     = push_idx;
    wdata     = '0;
    raddr     = top_idx;
    alu_req.start = 1'b0;
    alu_req.op    = kind_r;

    o_pc_nxt   = o_pc_r;
    o_pv_nxt   = o_pv_r;
    o_pval_nxt = o_pval_r;
    o_halt_nxt = o_halt_r;
    o_st_nxt   = o_st_r;
    ov_nxt     = ov_r && !out_ch.ready;

    unique case (state_r)
      S_CLR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == 32'(smx_pkg::STACK_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt  = in_ch.kind;
          lvl_nxt   = in_ch.level;
          off_nxt   = in_ch.offset;
          cst_nxt   = in_ch.constant;
          tgt_nxt   = in_ch.target;
          rdv_nxt   = in_ch.read_value;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        npc_nxt   = pc_inc;
        st_nxt    = smx_pkg::ST_OK;
        pv_nxt    = 1'b0;
        pval_nxt  = '0;
        state_nxt = S_OUT;
        if (halt_r) begin
          npc_nxt = pc_r;
        end else begin
          unique case (kind_r)
            smx_pkg::OP_SOMA, smx_pkg::OP_SUBT, smx_pkg::OP_MULT, smx_pkg::OP_DIVI,
            smx_pkg::OP_CONJ, smx_pkg::OP_DISJ, smx_pkg::OP_CMME, smx_pkg::OP_CMMA,
            smx_pkg::OP_CMIG, smx_pkg::OP_CMDG, smx_pkg::OP_CMEG,
            smx_pkg::OP_CMAG: begin
              if (!has2) st_nxt = smx_pkg::ST_STACK;
              else state_nxt = S_R1;
            end
            smx_pkg::OP_INVR, smx_pkg::OP_NEGA, smx_pkg::OP_DSVF,
            smx_pkg::OP_IMPR: begin
              if (!has1) st_nxt = smx_pkg::ST_STACK;
              else state_nxt = S_R1;
            end
            smx_pkg::OP_CRCT, smx_pkg::OP_LEIT: begin
              if (!can_push) begin
                st_nxt = smx_pkg::ST_STACK;
              end else begin
                we     = 1'b1;
                wdata  = (kind_r == smx_pkg::OP_CRCT) ? cst_r : rdv_r;
                sp_nxt = sp_r + SW'(1);
              end
            end
            smx_pkg::OP_DSVS: begin
              if (tgt_bad) st_nxt = smx_pkg::ST_ADDR;
              else npc_nxt = tgt_r;
            end
            smx_pkg::OP_NADA: begin
              st_nxt = smx_pkg::ST_OK;
            end
            smx_pkg::OP_INPP: begin
              sp_nxt      = '0;
              disp_nxt[0] = '0;
            end
            smx_pkg::OP_AMEM: begin
              if (!amem_ok) st_nxt = smx_pkg::ST_STACK;
              else sp_nxt = amem_t[SW-1:0];
            end
            smx_pkg::OP_DMEM: begin
              if (!dmem_ok) st_nxt = smx_pkg::ST_STACK;
              else sp_nxt = dmem_t[SW-1:0];
            end
            smx_pkg::OP_PARA: begin
              halt_nxt = 1'b1;
              npc_nxt  = pc_r;
            end
            smx_pkg::OP_CRVL, smx_pkg::OP_CRVI: begin
              if (!can_push) begin
                st_nxt = smx_pkg::ST_STACK;
              end else if (lvl_bad || !fa_ok) begin
                st_nxt = smx_pkg::ST_ADDR;
              end else begin
                raddr     = fa[AW-1:0];
                state_nxt = S_R1;
              end
            end
            smx_pkg::OP_CREN: begin
              if (!can_push) begin
                st_nxt = smx_pkg::ST_STACK;
              end else if (lvl_bad) begin
                st_nxt = smx_pkg::ST_ADDR;
              end else begin
                we     = 1'b1;
                wdata  = DW'(fa);
                sp_nxt = sp_r + SW'(1);
              end
            end
            smx_pkg::OP_ARMZ, smx_pkg::OP_ARMI: begin
              if (!has1) begin
                st_nxt = smx_pkg::ST_STACK;
              end else if (lvl_bad || !fa_ok) begin
                st_nxt = smx_pkg::ST_ADDR;
              end else begin
                a_nxt     = fa[AW-1:0];
                raddr     = (kind_r == smx_pkg::OP_ARMI) ? fa[AW-1:0] : top_idx;
                state_nxt = S_R1;
              end
            end
            smx_pkg::OP_CHPR: begin
              if (!can_push) begin
                st_nxt = smx_pkg::ST_STACK;
              end else if (tgt_bad) begin
                st_nxt = smx_pkg::ST_ADDR;
              end else begin
                we      = 1'b1;
                wdata   = DW'(pc_inc);
                sp_nxt  = sp_r + SW'(1);
                npc_nxt = tgt_r;
              end
            end
            smx_pkg::OP_ENPR: begin
              if (!can_push) begin
                st_nxt = smx_pkg::ST_STACK;
              end else if (lvl_bad) begin
                st_nxt = smx_pkg::ST_ADDR;
              end else begin
                we     = 1'b1;
                wdata  = DW'(disp_sel);
                sp_nxt = sp_r + SW'(1);
                disp_nxt[lvl_r[DAW-1:0]] = sp_r + SW'(1);
              end
            end
            default: begin
              // return from procedure
              if (!has2 || !rt_ok) st_nxt = smx_pkg::ST_STACK;
              else if (lvl_bad) st_nxt = smx_pkg::ST_ADDR;
              else state_nxt = S_R1;
            end
          endcase
        end
      end
      S_R1: begin
        state_nxt = S_OUT;
        unique case (kind_r)
          smx_pkg::OP_SOMA, smx_pkg::OP_SUBT, smx_pkg::OP_MULT, smx_pkg::OP_DIVI,
          smx_pkg::OP_CONJ, smx_pkg::OP_DISJ, smx_pkg::OP_CMME, smx_pkg::OP_CMMA,
          smx_pkg::OP_CMIG, smx_pkg::OP_CMDG, smx_pkg::OP_CMEG, smx_pkg::OP_CMAG,
          smx_pkg::OP_RTPR: begin
            y_nxt     = rdata;
            raddr     = sec_idx;
            state_nxt = S_R2;
          end
          smx_pkg::OP_INVR, smx_pkg::OP_NEGA: begin
            we    = 1'b1;
            waddr = top_idx;
            wdata = ((kind_r == smx_pkg::OP_INVR) ? DW'(0) : DW'(1)) - rdata;
          end
          smx_pkg::OP_DSVF: begin
            if (rdata == '0 && tgt_bad) begin
              st_nxt = smx_pkg::ST_ADDR;
            end else begin
              if (rdata == '0) npc_nxt = tgt_r;
              sp_nxt = sp_r - SW'(1);
            end
          end
          smx_pkg::OP_IMPR: begin
            pv_nxt   = 1'b1;
            pval_nxt = rdata;
            sp_nxt   = sp_r - SW'(1);
          end
          smx_pkg::OP_CRVL: begin
            we     = 1'b1;
            wdata  = rdata;
            sp_nxt = sp_r + SW'(1);
          end
          smx_pkg::OP_CRVI: begin
            if (!rd_addr_ok) begin
              st_nxt = smx_pkg::ST_ADDR;
            end else begin
              raddr     = rdata[AW-1:0];
              state_nxt = S_R2;
            end
          end
          smx_pkg::OP_ARMZ: begin
            we     = 1'b1;
            waddr  = a_r;
            wdata  = rdata;
            sp_nxt = sp_r - SW'(1);
          end
          smx_pkg::OP_ARMI: begin
            if (!rd_addr_ok) begin
              st_nxt = smx_pkg::ST_ADDR;
            end else begin
              a_nxt     = rdata[AW-1:0];
              state_nxt = S_R2;
            end
          end
          default: begin
            state_nxt = S_OUT;
          end
        endcase
      end
      S_R2: begin
        state_nxt = S_OUT;
        unique case (kind_r)
          smx_pkg::OP_DIVI: begin
            if (y_r == '0) begin
              st_nxt = smx_pkg::ST_DIV0;
            end else begin
              alu_req.start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          smx_pkg::OP_CRVI: begin
            we     = 1'b1;
            wdata  = rdata;
            sp_nxt = sp_r + SW'(1);
          end
          smx_pkg::OP_ARMI: begin
            we     = 1'b1;
            waddr  = a_r;
            wdata  = rdata;
            sp_nxt = sp_r - SW'(1);
          end
          smx_pkg::OP_RTPR: begin
            if (!rd_ret_ok || !base_ok) begin
              st_nxt = smx_pkg::ST_ADDR;
            end else begin
              disp_nxt[lvl_r[DAW-1:0]] = y_r[SW-1:0];
              npc_nxt = rdata[PW-1:0];
              sp_nxt  = rt_t[SW-1:0];
            end
          end
          default: begin
            we     = 1'b1;
            waddr  = sec_idx;
            wdata  = alu_res;
            sp_nxt = sp_r - SW'(1);
          end
        endcase
      end
      S_DIV: begin
        if (alu_rsp.done) begin
          we        = 1'b1;
          waddr     = sec_idx;
          wdata     = alu_quo;
          sp_nxt    = sp_r - SW'(1);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          o_pc_nxt   = npc_r;
          o_pv_nxt   = pv_r;
          o_pval_nxt = pval_r;
          o_halt_nxt = halt_r;
          o_st_nxt   = st_r;
          pc_nxt     = npc_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    lvl_r    <= lvl_nxt;
    off_r    <= off_nxt;
    cst_r    <= cst_nxt;
    tgt_r    <= tgt_nxt;
    rdv_r    <= rdv_nxt;
    npc_r    <= npc_nxt;
    a_r      <= a_nxt;
    y_r      <= y_nxt;
    st_r     <= st_nxt;
    pv_r     <= pv_nxt;
    pval_r   <= pval_nxt;
    o_pc_r   <= o_pc_nxt;
    o_pv_r   <= o_pv_nxt;
    o_pval_r <= o_pval_nxt;
    o_halt_r <= o_halt_nxt;
    o_st_r   <= o_st_nxt;
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      sp_r    <= '0;
      pc_r    <= '0;
      halt_r  <= 1'b0;
      ov_r    <= 1'b0;
      for (int i = 0; i < smx_pkg::DISPLAY_DEPTH; i++) begin
        disp_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      sp_r    <= sp_nxt;
      pc_r    <= pc_nxt;
      halt_r  <= halt_nxt;
      ov_r    <= ov_nxt;
      disp_r  <= disp_nxt;
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.next_pc     = o_pc_r;
  assign out_ch.print_valid = o_pv_r;
  assign out_ch.print_value = o_pval_r;
  assign out_ch.halted      = o_halt_r;
  assign out_ch.status      = o_st_r;

  sp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sp_r) <= 32'(smx_pkg::STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag dropped");

  halted_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (halt_r && state_r != S_DEC) |=> $stable(sp_r))
    else $error("stack pointer moved while halted");

  fault_no_print: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_st_r != smx_pkg::ST_OK) |-> !o_pv_r)
    else $error("print beat on a faulting instruction");

  div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.busy |-> state_r == S_DIV)
    else $error("divider busy outside divide state");

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for stack_machine_executor
// ----------------------------------------------------------------------------
// The bench drives decoded instructions into in_ch and checks every result
// beat on out_ch against a built-in executor model. That model keeps its own
// data stack, display, stack pointer, pc and halt flag.
//
// Stimulus runs in this order:
// - a short directed opening covering faults, extremes and wraparound
// - random instruction streams mixed with call/return sequences
// - a calm tail that executes halt and then keeps sending instructions
//
// Both handshakes idle in random bursts. Partway through the run the
// receiver holds off for a long stretch, and later the sender drains the
// machine before it goes on.
// ----------------------------------------------------------------------------
module tb;

  localparam int DW = smx_pkg::DATA_W;
  localparam int PW = smx_pkg::PC_W;

  typedef struct {
    logic [smx_pkg::KIND_W-1:0]        kind;
    logic [smx_pkg::LEVEL_W-1:0]       level;
    logic signed [smx_pkg::OFF_W-1:0]  offset;
    logic signed [smx_pkg::DATA_W-1:0] constant;
    logic [smx_pkg::PC_W-1:0]          target;
    logic signed [smx_pkg::DATA_W-1:0] read_value;
  } instr_t;

  typedef struct {
    logic [smx_pkg::PC_W-1:0]   next_pc;
    logic                       print_valid;
    logic [smx_pkg::DATA_W-1:0] print_value;
    logic                       halted;
    logic [smx_pkg::ST_W-1:0]   status;
  } outcome_t;

  class exec_scoreboard;
    logic [DW-1:0]     mem [smx_pkg::STACK_DEPTH];
    longint            disp [smx_pkg::DISPLAY_DEPTH];
    int                top;
    logic [PW-1:0]     pc;
    bit                halt;
    outcome_t          pending_results [$];
    int                errors;

    function new();
      foreach (mem[j]) mem[j] = '0;
      foreach (disp[j]) disp[j] = 0;
      top = -1;
      pc = '0;
      halt = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function bit frame(int k, longint n, output int a);
      longint v;
      a = 0;
      if (k >= smx_pkg::DISPLAY_DEPTH) return 0;
      v = disp[k] + n;
      if (v < 0 || v >= smx_pkg::STACK_DEPTH) return 0;
      a = int'(v);
      return 1;
    endfunction

    function outcome_t execute(instr_t it);
      outcome_t o;
      int s, a;
      logic [DW-1:0] x, y, r;
      longint sx, sy, t, ret, base, n;
      logic [smx_pkg::ST_W-1:0] st;
      bit can_push;
      s = top;
      n = it.offset;
      o.next_pc = (pc == smx_pkg::PROGRAM_DEPTH - 1) ? '0 : pc + 1'b1;
      o.print_valid = 0;
      o.print_value = '0;
      st = smx_pkg::ST_OK;
      can_push = s < smx_pkg::STACK_DEPTH - 1;
      r = '0;
      if (halt) o.next_pc = pc;
      else case (it.kind)
        smx_pkg::OP_SOMA, smx_pkg::OP_SUBT, smx_pkg::OP_MULT, smx_pkg::OP_DIVI,
        smx_pkg::OP_CONJ, smx_pkg::OP_DISJ, smx_pkg::OP_CMME, smx_pkg::OP_CMMA,
        smx_pkg::OP_CMIG, smx_pkg::OP_CMDG, smx_pkg::OP_CMEG, smx_pkg::OP_CMAG: begin
          if (s < 1) st = smx_pkg::ST_STACK;
          else begin
            x = mem[s-1];
            y = mem[s];
            sx = longint'(signed'(x));
            sy = longint'(signed'(y));
            case (it.kind)
              smx_pkg::OP_SOMA: r = x + y;
              smx_pkg::OP_SUBT: r = x - y;
              smx_pkg::OP_MULT: r = x * y;
              smx_pkg::OP_DIVI: begin
                if (y == 0) st = smx_pkg::ST_DIV0;
                else r = DW'(sx / sy);
              end
              smx_pkg::OP_CONJ: r = DW'(x == 1 && y == 1);
              smx_pkg::OP_DISJ: r = DW'(x == 1 || y == 1);
              smx_pkg::OP_CMME: r = DW'(sx < sy);
              smx_pkg::OP_CMMA: r = DW'(sx > sy);
              smx_pkg::OP_CMIG: r = DW'(sx == sy);
              smx_pkg::OP_CMDG: r = DW'(sx != sy);
              smx_pkg::OP_CMEG: r = DW'(sx <= sy);
              default: r = DW'(sx >= sy);
            endcase
            if (st == smx_pkg::ST_OK) begin
              mem[s-1] = r;
              s--;
            end
          end
        end
        smx_pkg::OP_INVR, smx_pkg::OP_NEGA: begin
          if (s < 0) st = smx_pkg::ST_STACK;
          else mem[s] = (it.kind == smx_pkg::OP_INVR ? 32'd0 : 32'd1) - mem[s];
        end
        smx_pkg::OP_CRCT, smx_pkg::OP_LEIT: begin
          if (!can_push) st = smx_pkg::ST_STACK;
          else begin
            s++;
            mem[s] = it.kind == smx_pkg::OP_CRCT ? it.constant : it.read_value;
          end
        end
        smx_pkg::OP_DSVS: o.next_pc = it.target;
        smx_pkg::OP_DSVF: begin
          if (s < 0) st = smx_pkg::ST_STACK;
          else begin
            if (mem[s] == 0) o.next_pc = it.target;
            s--;
          end
        end
        smx_pkg::OP_NADA: ;
        smx_pkg::OP_IMPR: begin
          if (s < 0) st = smx_pkg::ST_STACK;
          else begin
            o.print_valid = 1;
            o.print_value = mem[s];
            s--;
          end
        end
        smx_pkg::OP_INPP: begin
          s = -1;
          disp[0] = 0;
        end
        smx_pkg::OP_AMEM, smx_pkg::OP_DMEM: begin
          t = longint'(s) + (it.kind == smx_pkg::OP_AMEM ? n : -n);
          if (t < -1 || t > smx_pkg::STACK_DEPTH - 1) st = smx_pkg::ST_STACK;
          else s = int'(t);
        end
        smx_pkg::OP_PARA: begin
          halt = 1;
          o.next_pc = pc;
        end
        smx_pkg::OP_CRVL, smx_pkg::OP_CRVI, smx_pkg::OP_CREN: begin
          if (!can_push) st = smx_pkg::ST_STACK;
          else if (it.kind == smx_pkg::OP_CREN) begin
            s++;
            mem[s] = DW'(disp[it.level] + n);
          end else if (!frame(it.level, n, a)) st = smx_pkg::ST_ADDR;
          else begin
            if (it.kind == smx_pkg::OP_CRVI) begin
              t = longint'(signed'(mem[a]));
              if (t < 0 || t >= smx_pkg::STACK_DEPTH) st = smx_pkg::ST_ADDR;
              else a = int'(t);
            end
            if (st == smx_pkg::ST_OK) begin
              s++;
              mem[s] = mem[a];
            end
          end
        end
        smx_pkg::OP_ARMZ, smx_pkg::OP_ARMI: begin
          if (s < 0) st = smx_pkg::ST_STACK;
          else if (!frame(it.level, n, a)) st = smx_pkg::ST_ADDR;
          else begin
            if (it.kind == smx_pkg::OP_ARMI) begin
              t = longint'(signed'(mem[a]));
              if (t < 0 || t >= smx_pkg::STACK_DEPTH) st = smx_pkg::ST_ADDR;
              else a = int'(t);
            end
            if (st == smx_pkg::ST_OK) begin
              mem[a] = mem[s];
              s--;
            end
          end
        end
        smx_pkg::OP_CHPR: begin
          if (!can_push) st = smx_pkg::ST_STACK;
          else begin
            s++;
            mem[s] = DW'(o.next_pc);
            o.next_pc = it.target;
          end
        end
        smx_pkg::OP_ENPR: begin
          if (!can_push) st = smx_pkg::ST_STACK;
          else begin
            s++;
            mem[s] = DW'(disp[it.level]);
            disp[it.level] = s + 1;
          end
        end
        default: begin
          if (s < 1) st = smx_pkg::ST_STACK;
          else begin
            t = longint'(s) - (n + 2);
            ret = longint'(signed'(mem[s-1]));
            base = longint'(signed'(mem[s]));
            if (t < -1 || t > smx_pkg::STACK_DEPTH - 1) st = smx_pkg::ST_STACK;
            else if (ret < 0 || ret >= smx_pkg::PROGRAM_DEPTH) st = smx_pkg::ST_ADDR;
            else if (base < 0 || base > smx_pkg::STACK_DEPTH) st = smx_pkg::ST_ADDR;
            else begin
              disp[it.level] = base;
              o.next_pc = PW'(ret);
              s = int'(t);
            end
          end
        end
      endcase
      if (st != smx_pkg::ST_OK) begin
        s = top;
        o.print_valid = 0;
        o.print_value = '0;
        o.next_pc = (pc == smx_pkg::PROGRAM_DEPTH - 1) ? '0 : pc + 1'b1;
      end
      top = s;
      pc = o.next_pc;
      o.halted = halt;
      o.status = st;
      return o;
    endfunction

    function void note(instr_t it);
      pending_results.insert(pending_results.size(), execute(it));
    endfunction

    task check(outcome_t got);
      outcome_t e;
      if (pending_results.size() == 0) begin
        report("result beat with nothing pending");
        return;
      end
      e = pending_results.pop_front();
      if (got.next_pc !== e.next_pc)
        report($sformatf("next_pc %0d, want %0d", got.next_pc, e.next_pc));
      if (got.print_valid !== e.print_valid)
        report($sformatf("print_valid %0b, want %0b", got.print_valid, e.print_valid));
      if (got.print_value !== e.print_value)
        report($sformatf("print_value %h, want %h", got.print_value, e.print_value));
      if (got.halted !== e.halted)
        report($sformatf("halted %0b, want %0b", got.halted, e.halted));
      if (got.status !== e.status)
        report($sformatf("status %0d, want %0d", got.status, e.status));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  bit   calm = 0;
  bit   long_hold = 0;

  smx_in_if  in_if ();
  smx_out_if out_if ();

  stack_machine_executor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  exec_scoreboard sb = new();

  always #5 clk = ~clk;

  initial begin
    in_if.valid = 0;
    in_if.kind = '0;
    in_if.level = '0;
    in_if.offset = '0;
    in_if.constant = '0;
    in_if.target = '0;
    in_if.read_value = '0;
    out_if.ready = 0;
  end

  // receiver: random ready bursts, one long hold-off on request
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        out_if.ready = 0;
        repeat (300) @(negedge clk);
        long_hold = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_if.ready = 0;
        n = $urandom_range(1, 16);
        repeat (n) @(negedge clk);
      end else begin
        out_if.ready = 1;
        n = $urandom_range(1, 12);
        repeat (n) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    outcome_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.next_pc = out_if.next_pc;
      got.print_valid = out_if.print_valid;
      got.print_value = out_if.print_value;
      got.halted = out_if.halted;
      got.status = out_if.status;
      sb.check(got);
    end
  end

  task automatic send(instr_t it);
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_if.valid = 0;
      n = $urandom_range(1, 16);
      repeat (n) @(negedge clk);
    end
    in_if.kind = it.kind;
    in_if.level = it.level;
    in_if.offset = it.offset;
    in_if.constant = it.constant;
    in_if.target = it.target;
    in_if.read_value = it.read_value;
    in_if.valid = 1;
    do @(posedge clk); while (!in_if.ready);
    sb.note(it);
    @(negedge clk);
  endtask

  function automatic instr_t op(logic [smx_pkg::KIND_W-1:0] k, int lvl = 0, int off = 0,
                                logic [DW-1:0] c = '0, int tgt = 0);
    instr_t it;
    it.kind = k;
    it.level = lvl[smx_pkg::LEVEL_W-1:0];
    it.offset = off[smx_pkg::OFF_W-1:0];
    it.constant = c;
    it.target = tgt[smx_pkg::PC_W-1:0];
    it.read_value = $urandom();
    return it;
  endfunction

  task automatic drain();
    in_if.valid = 0;
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic instr_t random_instr();
    instr_t it;
    logic [DW-1:0] c;
    logic [smx_pkg::KIND_W-1:0] kind;
    int k, off;
    k = $urandom_range(0, 31);
    if (sb.top < 30 && $urandom_range(0, 9) < 4)
      k = $urandom_range(0, 1) ? smx_pkg::OP_CRCT
                               : ($urandom_range(0, 1) ? smx_pkg::OP_CRVL : smx_pkg::OP_LEIT);
    else if (sb.top > 60 && $urandom_range(0, 1) == 1)
      k = $urandom_range(smx_pkg::OP_SOMA, smx_pkg::OP_CMAG);
    if (k == smx_pkg::OP_PARA || k == smx_pkg::OP_INPP && $urandom_range(0, 3) != 0)
      k = smx_pkg::OP_NADA;
    off = $urandom_range(0, 15) == 0 ? int'($urandom_range(0, 2047)) - 1024
                                     : int'($urandom_range(0, 8)) - 2;
    case ($urandom_range(0, 7))
      0: c = 32'h7fffffff;
      1: c = 32'h80000000;
      2, 3: c = $urandom();
      default: c = $urandom_range(0, 12);
    endcase
    kind = k[smx_pkg::KIND_W-1:0];
    it = op(kind, $urandom_range(0, 7), off, c, $urandom_range(0, 4095));
    if ($urandom_range(0, 1)) it.read_value = $urandom_range(0, 12);
    return it;
  endfunction

  // call, frame entry, local work and return
  task automatic call_sequence();
    int k, m, j;
    k = $urandom_range(0, 7);
    m = $urandom_range(0, 3);
    for (j = 0; j < m; j++) send(op(smx_pkg::OP_CRCT, 0, 0, $urandom_range(0, 20)));
    send(op(smx_pkg::OP_CHPR, 0, 0, 0, $urandom_range(0, 4095)));
    send(op(smx_pkg::OP_ENPR, k));
    send(op(smx_pkg::OP_AMEM, 0, 2));
    send(op(smx_pkg::OP_CRCT, 0, 0, $urandom()));
    send(op(smx_pkg::OP_ARMZ, k, 1));
    send(op(smx_pkg::OP_CRVL, k, -3));
    send(op(smx_pkg::OP_ARMZ, k, 0));
    send(op(smx_pkg::OP_CRVI, k, 0));
    send(op(smx_pkg::OP_IMPR));
    send(op(smx_pkg::OP_DMEM, 0, 2));
    send(op(smx_pkg::OP_RTPR, k, m));
  endtask

  initial begin
    int i;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send(op(smx_pkg::OP_IMPR));
    send(op(smx_pkg::OP_CRCT, 0, 0, 32'h80000000));
    send(op(smx_pkg::OP_CRCT, 0, 0, 32'hffffffff));
    send(op(smx_pkg::OP_DIVI));
    send(op(smx_pkg::OP_CRCT, 0, 0, 32'h0));
    send(op(smx_pkg::OP_DIVI));
    send(op(smx_pkg::OP_INVR));
    send(op(smx_pkg::OP_NEGA));
    send(op(smx_pkg::OP_IMPR));
    send(op(smx_pkg::OP_INPP));
    send(op(smx_pkg::OP_AMEM, 0, 1023));
    send(op(smx_pkg::OP_CRCT, 0, 0, 32'h7fffffff));
    send(op(smx_pkg::OP_CREN, 7, 1023));
    send(op(smx_pkg::OP_DMEM, 0, 1023));
    send(op(smx_pkg::OP_DMEM, 0, 1));
    send(op(smx_pkg::OP_DSVS, 0, 0, 0, 4095));
    send(op(smx_pkg::OP_NADA));
    send(op(smx_pkg::OP_ENPR, 7));
    send(op(smx_pkg::OP_CRVL, 7, -1024));
    send(op(smx_pkg::OP_LEIT));
    send(op(smx_pkg::OP_CHPR, 0, 0, 0, 5));
    send(op(smx_pkg::OP_RTPR, 7, 0));
    send(op(smx_pkg::OP_CREN, 0, -1024));
    send(op(smx_pkg::OP_ARMI, 0, 0));
    send(op(smx_pkg::OP_DSVF, 0, 0, 0, 4095));

    for (i = 0; i < 220; i++) begin
      if (i == 60) long_hold = 1;
      if (i == 120) drain();
      if ($urandom_range(0, 19) == 0) call_sequence();
      else send(random_instr());
    end

    calm = 1;
    for (i = 0; i < 30; i++) send(random_instr());
    send(op(smx_pkg::OP_PARA));
    for (i = 0; i < 4; i++) send(random_instr());
    drain();
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/smx_pkg.sv
src/smx_if.sv
src/smx_ram.sv
src/smx_alu.sv
src/stack_machine_executor.sv
dv/tb.sv
